FILE: design/fba_pkg.sv
`timescale 1ns / 1ps
// fba_pkg: shared types and constants for the frame bitmap allocator
// depends on nothing; used by fba_ctrl, fba_datapath and frame_bitmap_allocator

package fba_pkg;

   // default geometry of the bitmap
   localparam int MAX_FRAMES_DEFAULT = 4096;
   localparam int WORD_BITS_DEFAULT  = 32;

   // fixed field widths
   localparam int FRAME_W     = 12;
   localparam int COUNT_W     = 13;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;

   // frame field covers 4096 frames at most
   localparam int FRAME_FIELD_LIMIT = 4096;

   localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 13'd4096;

   // operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_UPDATED = 2'd0,
      STATUS_NOTHING = 2'd1,
      STATUS_NO_FREE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RES_NOTHING,
      RES_FREED,
      RES_ALLOC,
      RES_NO_FREE
   } result_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DIVIDE,
      ST_FREE_READ,
      ST_FREE_WRITE,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic            clear_en;
      logic            accept;
      logic            scan_en;
      logic            div_en;
      logic            free_read;
      logic            free_write;
      logic            res_load;
      result_kind_type res_kind;
      logic            out_load;
   } fba_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clear_last;
      logic req_free;
      logic req_cur_zero;
      logic scan_found;
      logic scan_none;
      logic out_ready;
   } fba_status_type;

endpackage

FILE: design/frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// allocate: bitmap words are scanned from word 0 up to the one that holds a free
// frame (one word read and checked per cycle, up to 128 words by default);
// no free frame: the scan ends after the whole words below the scan limit
// free: word and bit from a reciprocal multiply, then a read and a write;
// nothing to do: no scan; one request is worked on at a time; csr writes always taken
// reset: synchronous; a clearing pass zeroes the bitmap one word a cycle (128 by default)

module frame_bitmap_allocator #(
   parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEFAULT,
   parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write: frame_count
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fba_pkg::COUNT_W-1:0]         csr_data,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [11:0] current_frame, [12] for_kernel, [13] want_writable, [15:14] zero
   input  logic [fba_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [0] operation
   input  logic [0:0]                          req_tuser,
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] page_present, [1] page_writable, [2] page_user, [14:3] page_frame, [15] zero
   output logic [fba_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [1:0] status
   output logic [fba_pkg::STATUS_W-1:0]        rsp_tuser
);

   fba_pkg::fba_cmd_type    cmd;
   fba_pkg::fba_status_type st;

   logic                        rsp_present;
   logic                        rsp_writable;
   logic                        rsp_user;
   logic [fba_pkg::FRAME_W-1:0] rsp_frame;

   // register port never stalls
   assign csr_ready = 1'b1;

   fba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   fba_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .WORD_BITS  (WORD_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data),
      .req_operation     (req_tuser[0]),
      .req_current_frame (req_tdata[11:0]),
      .req_for_kernel    (req_tdata[12]),
      .req_want_writable (req_tdata[13]),
      .cmd               (cmd),
      .st                (st),
      .rsp_tready        (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp_status        (rsp_tuser),
      .rsp_page_present  (rsp_present),
      .rsp_page_writable (rsp_writable),
      .rsp_page_user     (rsp_user),
      .rsp_page_frame    (rsp_frame)
   );

   // pack response fields
   assign rsp_tdata = {1'b0, rsp_frame, rsp_user, rsp_writable, rsp_present};

endmodule

FILE: design/fba_ctrl.sv
`timescale 1ns / 1ps
// fba_ctrl: sequencer of the frame bitmap allocator
// depends on fba_pkg; drives fba_datapath through command and status structs

module fba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  fba_pkg::fba_status_type st,
   output fba_pkg::fba_cmd_type    cmd
);

   fba_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fba_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.res_kind = fba_pkg::RES_NOTHING;
      req_tready = 1'b0;
      unique case (state_ff)
         fba_pkg::ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (st.clear_last) begin
               state_in = fba_pkg::ST_IDLE;
            end
         end
         fba_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               priority if (!st.req_free && !st.req_cur_zero) begin
                  // allocate for a page that already has a frame
                  cmd.res_load = 1'b1;
                  cmd.res_kind = fba_pkg::RES_NOTHING;
                  state_in     = fba_pkg::ST_DONE;
               end else if (st.req_free && st.req_cur_zero) begin
                  // free for a page with no frame
                  cmd.res_load = 1'b1;
                  cmd.res_kind = fba_pkg::RES_NOTHING;
                  state_in     = fba_pkg::ST_DONE;
               end else if (!st.req_free) begin
                  state_in = fba_pkg::ST_SCAN;
               end else begin
                  state_in = fba_pkg::ST_DIVIDE;
               end
            end
         end
         fba_pkg::ST_SCAN: begin
            cmd.scan_en = 1'b1;
            priority if (st.scan_found) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = fba_pkg::RES_ALLOC;
               state_in     = fba_pkg::ST_DONE;
            end else if (st.scan_none) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = fba_pkg::RES_NO_FREE;
               state_in     = fba_pkg::ST_DONE;
            end else begin
               state_in = fba_pkg::ST_SCAN;
            end
         end
         fba_pkg::ST_DIVIDE: begin
            cmd.div_en = 1'b1;
            state_in   = fba_pkg::ST_FREE_READ;
         end
         fba_pkg::ST_FREE_READ: begin
            cmd.free_read = 1'b1;
            state_in      = fba_pkg::ST_FREE_WRITE;
         end
         fba_pkg::ST_FREE_WRITE: begin
            cmd.free_write = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_kind   = fba_pkg::RES_FREED;
            state_in       = fba_pkg::ST_DONE;
         end
         fba_pkg::ST_DONE: begin
            if (st.out_ready) begin
               cmd.out_load = 1'b1;
               state_in     = fba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fba_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

FILE: design/fba_datapath.sv
`timescale 1ns / 1ps
// fba_datapath: bitmap memory, scan pipeline, index split, result registers
// depends on fba_pkg; commanded by fba_ctrl

module fba_datapath #(
   parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEFAULT,
   parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write
   input  logic                              csr_valid,
   input  logic [fba_pkg::COUNT_W-1:0]       csr_data,
   // live request payload
   input  logic                              req_operation,
   input  logic [fba_pkg::FRAME_W-1:0]       req_current_frame,
   input  logic                              req_for_kernel,
   input  logic                              req_want_writable,
   // controller link
   input  fba_pkg::fba_cmd_type              cmd,
   output fba_pkg::fba_status_type           st,
   // result channel
   input  logic                              rsp_tready,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_page_present,
   output logic                              rsp_page_writable,
   output logic                              rsp_page_user,
   output logic [fba_pkg::FRAME_W-1:0]       rsp_page_frame
);

   localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BW         = $clog2(WORD_BITS);
   localparam int QW         = (AW > fba_pkg::FRAME_W) ? AW : fba_pkg::FRAME_W;
   localparam int LIM_CAP    = (MAX_FRAMES < fba_pkg::FRAME_FIELD_LIMIT) ?
                               MAX_FRAMES : fba_pkg::FRAME_FIELD_LIMIT;
   localparam int FW         = fba_pkg::FRAME_W;
   localparam int CW         = fba_pkg::COUNT_W;
   // reciprocal of the word size, exact for every frame number of the field
   localparam int DIV_SHIFT  = FW + BW;
   localparam int DIV_MULT   = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
   localparam int PW         = 2 * FW + 8;

   // bitmap storage
   logic [WORD_BITS-1:0] mem [WORD_COUNT];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;

   // configuration and clearing pass
   logic [CW-1:0] frame_count_ff;
   logic [CW-1:0] lim;
   logic [AW-1:0] clr_addr_ff;

   // latched request
   logic [FW-1:0] cur_ff;
   logic          kern_ff;
   logic          wr_ff;

   // scan pipeline
   logic [CW-1:0] issue_base_ff;
   logic [AW-1:0] issue_addr_ff;
   logic          chk_valid_ff;
   logic [AW-1:0] chk_addr_ff;
   logic [FW-1:0] chk_base_ff;
   logic          can_issue;
   logic [WORD_BITS-1:0] inv_word;
   logic [WORD_BITS-1:0] low_bit;
   logic [BW-1:0] found_idx;
   logic          found;
   logic [FW-1:0] pick_frame;

   // index split
   logic [PW-1:0]        quot_prod;
   logic [FW-1:0]        quot_w;
   logic [FW-1:0]        rem_full;
   logic [FW-1:0]        quot_ff;
   logic [BW-1:0]        rem_ff;
   logic [QW-1:0]        quot_ext;
   logic [AW-1:0]        free_addr;
   logic                 in_range;

   // result and output registers
   fba_pkg::status_type res_status_ff;
   logic                res_present_ff;
   logic                res_writable_ff;
   logic                res_user_ff;
   logic [FW-1:0]       res_frame_ff;
   logic                rsp_valid_ff;
   fba_pkg::status_type rsp_status_ff;
   logic                rsp_present_ff;
   logic                rsp_writable_ff;
   logic                rsp_user_ff;
   logic [FW-1:0]       rsp_frame_ff;

   // frame count register, written on every csr transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= fba_pkg::FRAME_COUNT_RESET;
      end else if (csr_valid) begin
         frame_count_ff <= csr_data;
      end
   end

   // scan limit is the smallest of frame count, storage and frame field range
   assign lim = (frame_count_ff > CW'(LIM_CAP)) ? CW'(LIM_CAP) : frame_count_ff;

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // latch request on transfer
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_ff  <= req_current_frame;
         kern_ff <= req_for_kernel;
         wr_ff   <= req_want_writable;
      end
   end

   // scan: one word read issued per cycle, checked in the next cycle
   assign can_issue = (14'(issue_base_ff) + 14'(WORD_BITS)) <= 14'(lim);

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff <= 1'b0;
      end else if (cmd.accept) begin
         chk_valid_ff <= 1'b0;
      end else if (cmd.scan_en) begin
         chk_valid_ff <= can_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         issue_base_ff <= '0;
         issue_addr_ff <= '0;
      end else if (cmd.scan_en && can_issue) begin
         chk_addr_ff   <= issue_addr_ff;
         chk_base_ff   <= issue_base_ff[FW-1:0];
         issue_base_ff <= issue_base_ff + CW'(WORD_BITS);
         issue_addr_ff <= issue_addr_ff + AW'(1);
      end
   end

   // lowest clear bit of the checked word
   assign inv_word = ~rd_data_ff;
   assign low_bit  = inv_word & (~inv_word + WORD_BITS'(1));
   assign found    = chk_valid_ff && (inv_word != '0);

   always_comb begin
      found_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (low_bit[i]) begin
            found_idx = found_idx | BW'(i);
         end
      end
   end

   assign pick_frame = chk_base_ff + FW'(found_idx);

   // word and bit of the frame being freed by a reciprocal multiply, registered
   assign quot_prod = PW'(cur_ff) * PW'(DIV_MULT);
   assign quot_w    = quot_prod[DIV_SHIFT +: FW];
   assign rem_full  = cur_ff - quot_w * FW'(WORD_BITS);

   always_ff @(posedge clock) begin
      if (cmd.div_en) begin
         quot_ff <= quot_w;
         rem_ff  <= rem_full[BW-1:0];
      end
   end

   assign quot_ext  = QW'(quot_ff);
   assign free_addr = quot_ext[AW-1:0];
   assign in_range  = 32'(cur_ff) < MAX_FRAMES;

   // memory port selection
   assign rd_addr = cmd.free_read ? free_addr : issue_addr_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_addr_ff;
      mem_wdata = '0;
      priority if (cmd.clear_en) begin
         mem_we = 1'b1;
      end else if (cmd.scan_en && found) begin
         mem_we    = 1'b1;
         mem_waddr = chk_addr_ff;
         mem_wdata = rd_data_ff | low_bit;
      end else if (cmd.free_write && in_range) begin
         mem_we    = 1'b1;
         mem_waddr = free_addr;
         mem_wdata = rd_data_ff & ~(WORD_BITS'(1) << rem_ff);
      end else begin
         mem_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         unique case (cmd.res_kind)
            fba_pkg::RES_NOTHING: begin
               res_status_ff   <= fba_pkg::STATUS_NOTHING;
               res_present_ff  <= 1'b0;
               res_writable_ff <= 1'b0;
               res_user_ff     <= 1'b0;
               res_frame_ff    <= req_current_frame;
            end
            fba_pkg::RES_FREED: begin
               res_status_ff   <= fba_pkg::STATUS_UPDATED;
               res_present_ff  <= 1'b0;
               res_writable_ff <= 1'b0;
               res_user_ff     <= 1'b0;
               res_frame_ff    <= '0;
            end
            fba_pkg::RES_ALLOC: begin
               res_status_ff   <= fba_pkg::STATUS_UPDATED;
               res_present_ff  <= 1'b1;
               res_writable_ff <= wr_ff;
               res_user_ff     <= ~kern_ff;
               res_frame_ff    <= pick_frame;
            end
            fba_pkg::RES_NO_FREE: begin
               res_status_ff   <= fba_pkg::STATUS_NO_FREE;
               res_present_ff  <= 1'b0;
               res_writable_ff <= 1'b0;
               res_user_ff     <= 1'b0;
               res_frame_ff    <= '0;
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff   <= res_status_ff;
         rsp_present_ff  <= res_present_ff;
         rsp_writable_ff <= res_writable_ff;
         rsp_user_ff     <= res_user_ff;
         rsp_frame_ff    <= res_frame_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_page_present  = rsp_present_ff;
   assign rsp_page_writable = rsp_writable_ff;
   assign rsp_page_user     = rsp_user_ff;
   assign rsp_page_frame    = rsp_frame_ff;

   // status to controller
   assign st.clear_last   = clr_addr_ff == AW'(WORD_COUNT - 1);
   assign st.req_free     = req_operation == fba_pkg::OP_FREE;
   assign st.req_cur_zero = req_current_frame == '0;
   assign st.scan_found   = found;
   assign st.scan_none    = !found && !can_issue;
   assign st.out_ready    = !rsp_valid_ff || rsp_tready;

   // an allocated frame always lies below the scan limit
   assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_en && found) |-> (CW'(pick_frame) < lim))
      else $error("allocated frame beyond scan limit");

   // word and bit split matches the frame being freed
   assert property (@(posedge clock) disable iff (reset)
      cmd.free_write |->
         ((32'(quot_ff) * WORD_BITS + 32'(rem_ff)) == 32'(cur_ff)))
      else $error("free index split does not match frame");

   // a result enters the output register only when it is free
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten");

   // a new result appears only from a load
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load))
      else $error("result valid without load");

endmodule
